/* rtl/ieu_pkg.sv */
// Package: shared constants, types and opcodes of the execute unit.
`timescale 1ns / 1ps
`default_nettype none
package ieu_pkg;
  localparam int unsigned NumRegs    = 32;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned RegIdxW    = 5;
  localparam int unsigned XLen       = 32;
  localparam int unsigned BlkShift   = $clog2(BlockBytes);

  localparam logic [1:0] ModeInstr = 2'd0;
  localparam logic [1:0] ModeLoad  = 2'd1;
  localparam logic [1:0] ModeInval = 2'd2;

  localparam logic [1:0] ReqNone  = 2'd0;
  localparam logic [1:0] ReqLoad  = 2'd1;
  localparam logic [1:0] ReqStore = 2'd2;

  localparam logic [9:0] OpLw   = 10'd5;
  localparam logic [9:0] OpAddi = 10'd19;
  localparam logic [9:0] OpSw   = 10'd37;
  localparam logic [9:0] OpLr   = 10'd51;
  localparam logic [9:0] OpSc   = 10'd52;
  localparam logic [9:0] OpDiv  = 10'd56;
  localparam logic [9:0] OpAdd  = 10'd71;
  localparam logic [9:0] OpMul  = 10'd72;
  localparam logic [9:0] OpSub  = 10'd83;
  localparam logic [9:0] OpBeq  = 10'd99;
  localparam logic [9:0] OpBne  = 10'd100;
  localparam logic [9:0] OpJalr = 10'd103;
  localparam logic [9:0] OpJal  = 10'd111;
  localparam logic [9:0] OpHalt = 10'd999;

  typedef enum logic [2:0] {
    StIdle, StRead, StMul, StDiv, StOut
  } state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         opcode;
    logic [4:0]         field_one;
    logic [4:0]         field_two;
    logic [XLen-1:0]    field_three;
    logic [XLen-1:0]    pc_in;
    logic [XLen-1:0]    load_data;
    logic [27:0]        inval_block;
  } in_t;

  typedef struct packed {
    logic [XLen-1:0] next_pc;
    logic            halted;
    logic [1:0]      mem_req;
    logic [XLen-1:0] mem_addr;
    logic [XLen-1:0] mem_wdata;
    logic [4:0]      load_dest;
    logic            sc_failed;
  } out_t;

  typedef struct packed {
    logic start_mul;
    logic start_div;
  } md_ctl_t;

  typedef struct packed {
    logic            done;
    logic [XLen-1:0] result;
  } md_sts_t;
endpackage
`default_nettype wire

/* rtl/ieu_if.sv */
// Interface: valid/ready channel carrying one payload.
`timescale 1ns / 1ps
`default_nettype none
interface ieu_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ieu_mdu.sv */
// Bit-serial multiply and signed divide unit, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ieu_mdu import ieu_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire md_ctl_t         ctl_i,
  input  wire logic [XLen-1:0] op_a_i,
  input  wire logic [XLen-1:0] op_b_i,
  output md_sts_t              sts_o
);
  localparam int unsigned CntW = $clog2(XLen) + 1;
  logic              busy_q, busy_d, is_div_q, is_div_d, neg_q, neg_d, done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [XLen-1:0]   acc_q, acc_d, sh_q, sh_d, b_q, b_d;
  logic [XLen:0]     trial;
  logic [XLen-1:0]   ma, mb, rem_sh;

  assign ma = op_a_i[XLen-1] ? (XLen'(0) - op_a_i) : op_a_i;
  assign mb = op_b_i[XLen-1] ? (XLen'(0) - op_b_i) : op_b_i;
  assign rem_sh = {acc_q[XLen-2:0], sh_q[XLen-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, b_q};

  always_comb begin
    busy_d = busy_q; is_div_d = is_div_q; neg_d = neg_q; cnt_d = cnt_q;
    acc_d = acc_q; sh_d = sh_q; b_d = b_q; done_d = 1'b0;
    if (ctl_i.start_mul || ctl_i.start_div) begin
      busy_d = 1'b1; is_div_d = ctl_i.start_div; cnt_d = '0;
      acc_d = '0;
      neg_d = op_a_i[XLen-1] ^ op_b_i[XLen-1];
      sh_d = ctl_i.start_div ? ma : op_a_i;
      b_d = ctl_i.start_div ? mb : op_b_i;
    end else if (busy_q) begin
      if (is_div_q) begin
        if (!trial[XLen]) acc_d = trial[XLen-1:0];
        else acc_d = rem_sh;
        sh_d = {sh_q[XLen-2:0], ~trial[XLen]};
      end else begin
        if (b_q[0]) acc_d = acc_q + sh_q;
        sh_d = {sh_q[XLen-2:0], 1'b0};
        b_d = {1'b0, b_q[XLen-1:1]};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(XLen - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d; neg_q <= neg_d;
    acc_q <= acc_d; sh_q <= sh_d; b_q <= b_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.result = is_div_q ? (neg_q ? (XLen'(0) - sh_q) : sh_q) : acc_q;
endmodule
`default_nettype wire

/* rtl/integer_execute_unit_with_link.sv */
// Top level: execute stage with register file, link register and serial MDU.
// Channel | Dir | Payload
// in_if   | in  | mode, opcode, field_one..three, pc_in, load_data, inval_block
// out_if  | out | next_pc, halted, mem_req, mem_addr, mem_wdata, load_dest, sc_failed
// A result is registered from the StRead state after accept; mul and div with a
// nonzero divisor wait in StMul or StDiv for the bit-serial multiply/divide unit.
// One item at a time. Reset clears the register file to zero and drops the link.
// A result waits in the output register until taken; the next item can be
// accepted from the cycle after the result leaves.
`timescale 1ns / 1ps
`default_nettype none
module integer_execute_unit_with_link import ieu_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  ieu_if.sink      in_if,
  ieu_if.source    out_if
);
  state_e state_q, state_d;
  in_t    it_q;
  logic [XLen-1:0] rf_q [NumRegs];
  logic [XLen-1:0] a_q, b_q, c_q, link_q;
  logic            link_v_q;
  out_t   res_q, res_d;
  logic   ovalid_q, ovalid_d;
  logic   we; logic [RegIdxW-1:0] wa; logic [XLen-1:0] wd;
  logic   link_set, link_clr;
  md_ctl_t ctl; md_sts_t sts;
  logic [XLen-1:0] lo, la_off;
  logic [XLen-1:0] jalr_t;

  function automatic logic [XLen-1:0] rd(input logic [RegIdxW-1:0] i,
                                         input logic [XLen-1:0] f [NumRegs]);
    rd = (i == '0) ? '0 : f[i];
  endfunction

  ieu_mdu u_mdu (.clk_i, .rst_ni, .ctl_i(ctl), .op_a_i(b_q), .op_b_i(c_q), .sts_o(sts));

  assign in_if.ready = (state_q == StIdle) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.data = res_q;
  assign lo = {it_q.inval_block, {BlkShift{1'b0}}};
  assign la_off = link_q - lo;
  assign jalr_t = ((it_q.field_two == '0) ? '0 :
                   (it_q.field_two == it_q.field_one) ? it_q.pc_in : b_q) + it_q.field_three;

  always_comb begin
    state_d = state_q; res_d = res_q; ovalid_d = ovalid_q;
    we = 1'b0; wa = it_q.field_one; wd = '0; link_set = 1'b0; link_clr = 1'b0;
    ctl = '0;
    if (ovalid_q && out_if.ready) ovalid_d = 1'b0;
    case (state_q)
      StIdle: if (in_if.valid && in_if.ready) state_d = StRead;
      StRead: begin
        res_d = '0; res_d.next_pc = it_q.pc_in;
        state_d = StOut;
        if (it_q.mode == ModeLoad) begin
          we = 1'b1; wd = it_q.load_data;
        end else if (it_q.mode == ModeInval) begin
          if (link_v_q && (link_q[XLen-1:BlkShift] == it_q.inval_block)
              && (la_off < XLen'(BlockBytes))) link_clr = 1'b1;
        end else if (it_q.mode == ModeInstr) begin
          case (it_q.opcode)
            OpLw, OpLr: begin
              res_d.mem_req = ReqLoad; res_d.mem_addr = b_q + it_q.field_three;
              res_d.load_dest = it_q.field_one;
              link_set = (it_q.opcode == OpLr);
            end
            OpSw: begin
              res_d.mem_req = ReqStore; res_d.mem_addr = a_q + it_q.field_three;
              res_d.mem_wdata = b_q;
            end
            OpSc: begin
              if (link_v_q && a_q == link_q) begin
                res_d.mem_req = ReqStore; res_d.mem_addr = a_q + it_q.field_three;
                res_d.mem_wdata = b_q;
              end else begin
                res_d.sc_failed = 1'b1; we = 1'b1; wa = it_q.field_two; wd = '0;
              end
            end
            OpAddi: begin we = 1'b1; wd = b_q + it_q.field_three; end
            OpAdd:  begin we = 1'b1; wd = b_q + c_q; end
            OpSub:  begin we = 1'b1; wd = b_q - c_q; end
            OpMul:  begin ctl.start_mul = 1'b1; state_d = StMul; end
            OpDiv:  if (c_q != '0) begin ctl.start_div = 1'b1; state_d = StDiv; end
            OpBeq:  if (a_q == b_q) res_d.next_pc = it_q.pc_in + {it_q.field_three[XLen-3:0], 2'b00};
            OpBne:  if (a_q != b_q) res_d.next_pc = it_q.pc_in + {it_q.field_three[XLen-3:0], 2'b00};
            OpJalr: begin we = 1'b1; wd = it_q.pc_in; res_d.next_pc = jalr_t; end
            OpJal:  begin
              we = 1'b1; wd = it_q.pc_in; res_d.next_pc = it_q.pc_in + it_q.field_three;
            end
            OpHalt: res_d.halted = 1'b1;
            default: ;
          endcase
        end
        if (state_d == StOut) ovalid_d = 1'b1;
        if (state_d == StOut) state_d = StIdle;
      end
      StMul, StDiv: if (sts.done) begin
        we = 1'b1; wd = sts.result; ovalid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ovalid_q <= 1'b0; link_v_q <= 1'b0; link_q <= '1;
      for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d;
      if (we && wa != '0) rf_q[wa] <= wd;
      if (link_set) begin link_v_q <= 1'b1; link_q <= b_q; end
      else if (link_clr) begin link_v_q <= 1'b0; link_q <= '1; end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_if.valid && in_if.ready) begin
      it_q <= in_if.data;
      a_q <= rd(in_if.data.field_one, rf_q);
      b_q <= rd(in_if.data.field_two, rf_q);
      c_q <= rd(in_if.data.field_three[RegIdxW-1:0], rf_q);
    end
  end
endmodule
`default_nettype wire

/* rtl/ieu_checker.sv */
// Checker: port-level assertions on the execute unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ieu_checker import ieu_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input accepted while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_req_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.mem_req != 2'd3) else $error("bad mem_req");
  a_scf_noreq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.sc_failed |-> out_data.mem_req == ReqNone) else $error("sc req");
endmodule

bind integer_execute_unit_with_link ieu_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data));
`default_nettype wire

/* dv/tb_integer_execute_unit_with_link.sv */
// Testbench: randomized and directed check of the execute unit against a behavioral predictor.
`timescale 1ns / 1ps
module tb_integer_execute_unit_with_link;
  import ieu_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ieu_if #(.T(in_t))  in_if ();
  ieu_if #(.T(out_t)) out_if ();

  integer_execute_unit_with_link DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [XLen-1:0] regs_q [NumRegs];
  logic [XLen-1:0] link_addr_q;
  bit              link_ok_q;
  out_t            expected_q [$];
  int              errors = 0;
  int              n_results = 0;
  int              n_items = 0;
  int unsigned     cycles = 0;
  bit              no_idle = 1'b0;
  bit              hold_sink = 1'b0;
  logic [9:0]      ops [14] = '{OpLw, OpAddi, OpSw, OpLr, OpSc, OpDiv, OpAdd,
                                OpMul, OpSub, OpBeq, OpBne, OpJalr, OpJal, OpHalt};

  function automatic logic [XLen-1:0] rd(logic [4:0] i);
    return (i == 0) ? '0 : regs_q[i];
  endfunction

  function automatic void wr(logic [4:0] i, logic [XLen-1:0] v);
    if (i != 0) regs_q[i] = v;
  endfunction

  function automatic out_t execute(in_t t);
    out_t o;
    logic [XLen-1:0] a, b, c, pc;
    logic [35:0] lo;
    o = '0;
    pc = t.pc_in;
    a = rd(t.field_one);
    b = rd(t.field_two);
    c = rd(t.field_three[4:0]);
    if (t.mode == ModeLoad) begin
      wr(t.field_one, t.load_data);
    end else if (t.mode == ModeInval) begin
      lo = {t.inval_block, 4'b0};
      if (link_ok_q && {4'b0, link_addr_q} >= lo && {4'b0, link_addr_q} < lo + BlockBytes) begin
        link_ok_q = 1'b0;
        link_addr_q = '1;
      end
    end else if (t.mode == ModeInstr) begin
      case (t.opcode)
        OpLw: begin
          o.mem_req = ReqLoad; o.mem_addr = b + t.field_three; o.load_dest = t.field_one;
        end
        OpLr: begin
          link_addr_q = b; link_ok_q = 1'b1;
          o.mem_req = ReqLoad; o.mem_addr = b + t.field_three; o.load_dest = t.field_one;
        end
        OpSw: begin
          o.mem_req = ReqStore; o.mem_addr = a + t.field_three; o.mem_wdata = b;
        end
        OpSc: begin
          if (link_ok_q && a == link_addr_q) begin
            o.mem_req = ReqStore; o.mem_addr = a + t.field_three; o.mem_wdata = b;
          end else begin
            o.sc_failed = 1'b1;
            wr(t.field_two, '0);
          end
        end
        OpAddi: wr(t.field_one, b + t.field_three);
        OpAdd:  wr(t.field_one, b + c);
        OpSub:  wr(t.field_one, b - c);
        OpMul:  wr(t.field_one, b * c);
        OpDiv:  if (c != 0) wr(t.field_one, (b == 32'h8000_0000 && c == '1) ? b :
                                 $unsigned($signed(b) / $signed(c)));
        OpBeq:  if (a == b) pc = pc + (t.field_three << 2);
        OpBne:  if (a != b) pc = pc + (t.field_three << 2);
        OpJalr: begin
          wr(t.field_one, pc);
          pc = rd(t.field_two) + t.field_three;
        end
        OpJal: begin
          wr(t.field_one, pc);
          pc = pc + t.field_three;
        end
        OpHalt: o.halted = 1'b1;
        default: ;
      endcase
    end
    o.next_pc = pc;
    return o;
  endfunction

  task automatic report(string what, logic [XLen-1:0] got, logic [XLen-1:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  task automatic send(in_t t);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= t;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back(execute(t));
    n_items++;
  endtask

  function automatic in_t rand_item();
    in_t t;
    t.mode = ($urandom_range(0, 9) < 7) ? ModeInstr : 2'($urandom_range(1, 3));
    t.opcode = ($urandom_range(0, 9) == 0) ? 10'($urandom) : ops[$urandom_range(0, 13)];
    t.field_one = 5'($urandom);
    t.field_two = 5'($urandom);
    case ($urandom_range(0, 3))
      0: t.field_three = $urandom;
      1: t.field_three = $urandom_range(0, 63) - 32;
      default: t.field_three = {$urandom_range(0, 1) ? 27'h7ffffff : 27'h0, 5'($urandom)};
    endcase
    t.pc_in = $urandom;
    t.load_data = $urandom_range(0, 3) == 0 ? 32'h8000_0000 >> $urandom_range(0, 1) : $urandom;
    t.inval_block = 28'($urandom);
    return t;
  endfunction

  function automatic in_t mk(logic [1:0] m, logic [9:0] op, logic [4:0] f1, logic [4:0] f2,
                             logic [XLen-1:0] f3);
    in_t t;
    t = rand_item();
    t.mode = m; t.opcode = op; t.field_one = f1; t.field_two = f2; t.field_three = f3;
    return t;
  endfunction

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic test_directed();
    in_t t;
    t = mk(ModeLoad, OpLw, 5'd1, '0, '0); t.load_data = 32'h8000_0000; send(t);
    t = mk(ModeLoad, OpLw, 5'd2, '0, '0); t.load_data = 32'hffff_ffff; send(t);
    t = mk(ModeLoad, OpLw, 5'd0, '0, '0); t.load_data = 32'h1234_5678; send(t);
    send(mk(ModeInstr, OpDiv, 5'd3, 5'd1, 32'd2));
    send(mk(ModeInstr, OpDiv, 5'd4, 5'd1, 32'd0));
    send(mk(ModeInstr, OpMul, 5'd5, 5'd1, 32'd2));
    send(mk(ModeInstr, OpAdd, 5'd6, 5'd2, 32'd1));
    send(mk(ModeInstr, OpSub, 5'd7, 5'd2, 32'd1));
    send(mk(ModeInstr, OpAddi, 5'd8, 5'd0, 32'h7fff_ffff));
    send(mk(ModeInstr, OpLr, 5'd9, 5'd8, 32'd4));
    send(mk(ModeInstr, OpSc, 5'd8, 5'd2, 32'd0));
    t = mk(ModeInval, OpLw, '0, '0, '0); t.inval_block = 28'h7ff_ffff; send(t);
    send(mk(ModeInstr, OpSc, 5'd8, 5'd2, 32'd0));
    send(mk(ModeInstr, OpSc, 5'd8, 5'd0, 32'd0));
    send(mk(ModeInstr, OpSw, 5'd1, 5'd2, 32'hffff_fffc));
    send(mk(ModeInstr, OpBeq, 5'd0, 5'd0, 32'h8000_0000));
    send(mk(ModeInstr, OpBne, 5'd1, 5'd0, 32'hffff_ffff));
    send(mk(ModeInstr, OpJalr, 5'd10, 5'd10, 32'd8));
    send(mk(ModeInstr, OpJal, 5'd11, 5'd0, 32'hffff_fff0));
    send(mk(ModeInstr, OpHalt, 5'd31, 5'd31, 32'hffff_ffff));
    send(mk(ModeInstr, 10'h3ff, 5'd12, 5'd1, 32'd1));
    send(mk(2'd3, OpAddi, 5'd13, 5'd1, 32'd1));
    drain();
  endtask

  // lr / sc sequences with invalidations near the link
  task automatic test_link_sequences(int n);
    in_t t;
    logic [4:0] base;
    logic [XLen-1:0] bv;
    repeat (n) begin
      base = 5'($urandom_range(1, 31));
      t = mk(ModeLoad, OpLw, base, '0, '0); t.load_data = $urandom; send(t);
      send(mk(ModeInstr, OpLr, 5'($urandom), base, $urandom_range(0, 12)));
      if ($urandom_range(0, 1)) begin
        t = mk(ModeInval, OpLw, '0, '0, '0);
        bv = rd(base);
        t.inval_block = bv[31:4] + 28'($urandom_range(0, 2)) - 28'd1;
        send(t);
      end
      send(mk(ModeInstr, OpSc, $urandom_range(0, 2) ? base : 5'($urandom), 5'($urandom),
              $urandom_range(0, 12)));
    end
  endtask

  task automatic test_random(int n);
    repeat (n) send(rand_item());
  endtask

  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      test_random(8);
    join
    drain();
  endtask

  // sink: accepts results with random stalls, compares against the oldest prediction
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", out_if.data.next_pc, '0);
        end else begin
          out_t w, g;
          w = expected_q.pop_front();
          g = out_if.data;
          n_results++;
          if (g.next_pc !== w.next_pc) report("next_pc", g.next_pc, w.next_pc);
          if (g.halted !== w.halted) report("halted", 32'(g.halted), 32'(w.halted));
          if (g.mem_req !== w.mem_req) report("mem_req", 32'(g.mem_req), 32'(w.mem_req));
          if (g.mem_addr !== w.mem_addr) report("mem_addr", g.mem_addr, w.mem_addr);
          if (g.mem_wdata !== w.mem_wdata) report("mem_wdata", g.mem_wdata, w.mem_wdata);
          if (g.load_dest !== w.load_dest) report("load_dest", 32'(g.load_dest), 32'(w.load_dest));
          if (g.sc_failed !== w.sc_failed) report("sc_failed", 32'(g.sc_failed), 32'(w.sc_failed));
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (hold_sink) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < NumRegs; i++) regs_q[i] = '0;
    link_addr_q = '1;
    link_ok_q = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_link_sequences(40);
    test_backpressure();
    test_random(300);
    drain();
    no_idle = 1'b1;
    test_link_sequences(10);
    test_random(100);
    drain();
    $display("covered %0d items: all opcodes, load returns, link invalidation, sc pass/fail,",
             n_items);
    $display("divide corner cases and long output back-pressure; %0d results checked", n_results);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* integer_execute_unit_with_link.f */
rtl/ieu_pkg.sv
rtl/ieu_if.sv
rtl/ieu_mdu.sv
rtl/integer_execute_unit_with_link.sv
rtl/ieu_checker.sv
dv/tb_integer_execute_unit_with_link.sv
